// ===== rtl/rrcs_pkg.sv =====
// rrcs_pkg: shared types for the round-robin context switcher
// item structs, saved-context row and opcode codes; no dependencies
`timescale 1ns / 1ps

package rrcs_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_START  = 2'd1,
    OP_FINISH = 2'd2,
    OP_TICK   = 2'd3
  } opcode_e;

  // stack frame offset applied to the stack top on task start
  localparam logic [31:0] StartSpOffset = 32'd8;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  slot;
    logic [31:0] saved_sp;
    logic [31:0] saved_bp;
    logic [31:0] saved_di;
    logic [31:0] saved_si;
    logic [31:0] saved_d;
    logic [31:0] saved_c;
    logic [31:0] saved_b;
    logic [31:0] saved_a;
    logic [31:0] saved_ip;
    logic [31:0] saved_flags;
  } in_t;

  typedef struct packed {
    logic [2:0]  chosen_slot;
    logic        found;
    logic [31:0] next_sp;
    logic [31:0] next_ip;
    logic [31:0] next_a;
    logic [31:0] next_b;
    logic [31:0] next_c;
    logic [31:0] next_d;
    logic [31:0] next_si;
    logic [31:0] next_di;
    logic [31:0] next_bp;
    logic [31:0] next_flags;
  } out_t;

  // one row of the context memory: the saved registers of one slot
  typedef struct packed {
    logic [31:0] sp;
    logic [31:0] ip;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] si;
    logic [31:0] di;
    logic [31:0] bp;
    logic [31:0] flags;
  } ctx_t;

endpackage

// ===== rtl/rrcs_arbiter.sv =====
// rrcs_arbiter: round-robin pick after the current slot and first free slot from 1 up
// purely combinational; uses nothing from the package
`timescale 1ns / 1ps

module rrcs_arbiter #(
  parameter int MaxTasks = 8,
  parameter int IdxW     = $clog2(MaxTasks)
) (
  input  logic [MaxTasks-1:0] alloc_valid_i,
  input  logic [MaxTasks-1:0] rr_valid_i,
  input  logic [IdxW-1:0]     cur_i,
  output logic [IdxW-1:0]     rr_idx_o,
  output logic                rr_found_o,
  output logic [IdxW-1:0]     free_idx_o,
  output logic                free_found_o
);

  // scan descending so the nearest candidate after cur_i wins
  always_comb begin
    int s;
    rr_idx_o   = cur_i;
    rr_found_o = 1'b0;
    for (int k = MaxTasks; k >= 1; k--) begin
      s = int'(cur_i) + k;
      if (s >= MaxTasks) s = s - MaxTasks;
      if (rr_valid_i[s]) begin
        rr_idx_o   = IdxW'(s);
        rr_found_o = 1'b1;
      end
    end
  end

  // slot 0 belongs to the boot task and is never handed out
  always_comb begin
    free_idx_o   = '0;
    free_found_o = 1'b0;
    for (int i = MaxTasks - 1; i >= 1; i--) begin
      if (!alloc_valid_i[i]) begin
        free_idx_o   = IdxW'(i);
        free_found_o = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/rrcs_ctx_mem.sv =====
// rrcs_ctx_mem: saved-context memory, one row per task slot
// one write and one registered read per cycle; uses ctx_t from rrcs_pkg
`timescale 1ns / 1ps

module rrcs_ctx_mem
  import rrcs_pkg::*;
#(
  parameter int Depth = 8,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  ctx_t             wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output ctx_t             rdata_o
);

  ctx_t mem_q [Depth];
  ctx_t rdata_q;

  // read returns the old row on a same-address write; the caller forwards
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/round_robin_context_switcher.sv =====
// round_robin_context_switcher: task table with round-robin context switch on tick
// depends on rrcs_pkg, rrcs_arbiter and rrcs_ctx_mem
//
//   channel  direction  handshake                 payload
//   input    in         in_valid_i / in_stall_o   in_i  (in_t)
//   output   out        out_valid_o / out_stall_i out_o (out_t)
//
// an item is held in the input register, then its result in the result register
// that drives the output; one item per cycle is sustained while out_stall_i is low
// the valid-bit scan and context memory access happen between the input register
// and the result register and read/write port of the memory
// reset clears valid bits, current slot and pipeline valids and sets first_q;
// the context memory has no reset and no clearing pass
// a stalled valid result holds both stages; input stalls only when full
`timescale 1ns / 1ps

module round_robin_context_switcher
  import rrcs_pkg::*;
#(
  parameter int MAX_TASKS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  localparam int IdxW = $clog2(MAX_TASKS);

  logic                 s1_valid_q;
  in_t                  s1_q;
  logic                 out_valid_q;
  logic                 res_tick_q;
  logic                 res_fwd_q;
  logic [2:0]           res_slot_q;
  logic                 res_found_q;
  ctx_t                 fwd_ctx_q;

  logic [MAX_TASKS-1:0] valid_q, valid_d;
  logic [IdxW-1:0]      cur_q, cur_d;
  logic                 first_q, first_d;

  logic                 advance;
  logic                 do_item;
  opcode_e              op;
  logic [MAX_TASKS-1:0] eff_valid;
  logic [IdxW-1:0]      eff_cur;
  logic [IdxW-1:0]      fin_idx;
  logic [IdxW-1:0]      rr_idx, free_idx;
  logic                 rr_found, free_found;
  logic [IdxW-1:0]      new_cur;
  ctx_t                 tick_ctx, start_ctx, rd_ctx, res_ctx;
  logic                 mem_we, mem_re;
  logic [IdxW-1:0]      mem_waddr;
  ctx_t                 mem_wdata;
  logic [2:0]           slot_d;
  logic                 found_d;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign do_item    = s1_valid_q && advance;
  assign op         = opcode_e'(s1_q.opcode);

  // first tick makes slot 0 current and valid before the save
  assign eff_cur   = first_q ? '0 : cur_q;
  assign eff_valid = valid_q | {{(MAX_TASKS-1){1'b0}}, first_q};
  assign fin_idx   = IdxW'(s1_q.slot);
  assign new_cur   = rr_found ? rr_idx : eff_cur;

  rrcs_arbiter #(
    .MaxTasks(MAX_TASKS),
    .IdxW    (IdxW)
  ) u_arbiter (
    .alloc_valid_i(valid_q),
    .rr_valid_i   (eff_valid),
    .cur_i        (eff_cur),
    .rr_idx_o     (rr_idx),
    .rr_found_o   (rr_found),
    .free_idx_o   (free_idx),
    .free_found_o (free_found)
  );

  always_comb begin
    tick_ctx.sp    = s1_q.saved_sp;
    tick_ctx.ip    = s1_q.saved_ip;
    tick_ctx.a     = s1_q.saved_a;
    tick_ctx.b     = s1_q.saved_b;
    tick_ctx.c     = s1_q.saved_c;
    tick_ctx.d     = s1_q.saved_d;
    tick_ctx.si    = s1_q.saved_si;
    tick_ctx.di    = s1_q.saved_di;
    tick_ctx.bp    = s1_q.saved_bp;
    tick_ctx.flags = s1_q.saved_flags;
    start_ctx      = '0;
    start_ctx.sp   = s1_q.saved_sp - StartSpOffset;
    start_ctx.ip   = s1_q.saved_ip;
  end

  always_comb begin
    valid_d   = valid_q;
    cur_d     = cur_q;
    first_d   = first_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = eff_cur;
    mem_wdata = tick_ctx;
    slot_d    = '0;
    found_d   = 1'b0;
    if (do_item) begin
      case (op)
        OP_CLEAR: begin
          valid_d = '0;
        end
        OP_START: begin
          if (free_found) begin
            valid_d[free_idx] = 1'b1;
            mem_we            = 1'b1;
            mem_waddr         = free_idx;
            mem_wdata         = start_ctx;
            slot_d            = 3'(free_idx);
            found_d           = 1'b1;
          end
        end
        OP_FINISH: begin
          if (int'(s1_q.slot) < MAX_TASKS) begin
            valid_d[fin_idx] = 1'b0;
          end
        end
        OP_TICK: begin
          valid_d = eff_valid;
          first_d = 1'b0;
          cur_d   = new_cur;
          mem_we  = 1'b1;
          mem_re  = 1'b1;
          slot_d  = 3'(new_cur);
          found_d = rr_found;
        end
        default: begin
          valid_d = valid_q;
        end
      endcase
    end
  end

  rrcs_ctx_mem #(
    .Depth(MAX_TASKS),
    .AddrW(IdxW)
  ) u_ctx_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(new_cur),
    .rdata_o(rd_ctx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      cur_q       <= '0;
      first_q     <= 1'b1;
    end else begin
      valid_q <= valid_d;
      cur_q   <= cur_d;
      first_q <= first_d;
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_q <= in_i;
    end
    if (do_item) begin
      res_tick_q  <= (op == OP_TICK);
      res_fwd_q   <= (new_cur == eff_cur);
      res_slot_q  <= slot_d;
      res_found_q <= found_d;
      fwd_ctx_q   <= tick_ctx;
    end
  end

  // the selected slot may be the one just saved: take the saved item directly
  assign res_ctx = !res_tick_q ? '0 : (res_fwd_q ? fwd_ctx_q : rd_ctx);

  always_comb begin
    out_o.chosen_slot = res_slot_q;
    out_o.found       = res_found_q;
    out_o.next_sp     = res_ctx.sp;
    out_o.next_ip     = res_ctx.ip;
    out_o.next_a      = res_ctx.a;
    out_o.next_b      = res_ctx.b;
    out_o.next_c      = res_ctx.c;
    out_o.next_d      = res_ctx.d;
    out_o.next_si     = res_ctx.si;
    out_o.next_di     = res_ctx.di;
    out_o.next_bp     = res_ctx.bp;
    out_o.next_flags  = res_ctx.flags;
  end

  assign out_valid_o = out_valid_q;

endmodule
